// ----- rtl/lckm_pkg.sv -----
// Types and keyword table for the line command keyword matcher.
package lckm_pkg;

    localparam int KW_SLOTS   = 16;
    localparam int KW_MAXLEN  = 10;
    localparam int KW_POS_W   = 4;
    localparam int KW_INDEX_W = 4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Unused slots have length zero and never match.
    localparam logic [KW_POS_W-1:0] KW_LEN [KW_SLOTS] = '{
        4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd6, 4'd4, 4'd8,
        4'd10, 4'd3, 4'd6, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam logic [7:0] KW_TEXT [KW_SLOTS][KW_MAXLEN] = '{
        '{"f", "a", "n", "1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "n", "2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "n", "3", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "n", "4", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "a", "n", "u", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "u", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "v", "e", "r", "v", "i", "e", "w", 8'h00, 8'h00},
        '{"c", "o", "n", "t", "r", "o", "l", "l", "e", "r"},
        '{"l", "o", "w", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "e", "d", "i", "u", "m", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "i", "g", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic                  line_done;
        logic                  keyword_found;
        logic [KW_INDEX_W-1:0] keyword_index;
    } match_result_t;

endpackage

// ----- rtl/lckm_match.sv -----
// Per-byte candidate update and line-end keyword lookup.
module lckm_match #(
    parameter int KEYWORD_COUNT = 12,
    parameter int LINE_LIMIT    = 100,
    parameter int LEN_W         = 7
) (
    input  logic [7:0]               rx_byte,
    input  logic [KEYWORD_COUNT-1:0] cand,
    input  logic [LEN_W-1:0]         line_length,
    output logic [KEYWORD_COUNT-1:0] cand_next,
    output logic [LEN_W-1:0]         line_length_next,
    output lckm_pkg::match_result_t  result
);
    import lckm_pkg::*;

    localparam logic [LEN_W-1:0] KEEP_MAX = LEN_W'(LINE_LIMIT - 1);

    logic                    is_end;
    logic [KW_POS_W-1:0]     pos;
    logic [KEYWORD_COUNT-1:0] still;
    logic                    hit;
    logic [KW_INDEX_W-1:0]   hit_index;

    assign is_end = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign pos    = line_length[KW_POS_W-1:0];

    always_comb
    begin
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            still[k] = cand[k] && (line_length < LEN_W'(KW_LEN[k]))
                       && (KW_TEXT[k][pos] == rx_byte);
        end
    end

    // Lowest index wins
    always_comb
    begin
        hit       = 1'b0;
        hit_index = '0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
        begin
            if (cand[k] && (LEN_W'(KW_LEN[k]) == line_length) && (line_length != '0))
            begin
                hit       = 1'b1;
                hit_index = KW_INDEX_W'(k);
            end
        end
    end

    always_comb
    begin
        cand_next        = cand;
        line_length_next = line_length;
        if (is_end)
        begin
            cand_next        = {KEYWORD_COUNT{1'b1}};
            line_length_next = '0;
        end
        else if (line_length < KEEP_MAX)
        begin
            cand_next        = still;
            line_length_next = line_length + LEN_W'(1);
        end
    end

    assign result.line_done     = is_end;
    assign result.keyword_found = is_end && hit;
    assign result.keyword_index = is_end ? hit_index : '0;

endmodule

// ----- rtl/line_command_keyword_matcher.sv -----
// Line command keyword matcher: echoes bytes and matches ended lines against keywords.
// Each rx transfer loads its result into the output register.
// Throughput: one byte per cycle; the output register takes a new result while
// the previous one is being taken, so rx_ready only drops when res is stalled.
// Reset: candidate bits all ones, line length zero, no result pending.
module line_command_keyword_matcher #(
    parameter int LINE_LIMIT    = 100,
    parameter int KEYWORD_COUNT = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rx_valid,
    output logic                              rx_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [7:0]                        echo_byte,
    output logic                              line_done,
    output logic                              keyword_found,
    output logic [lckm_pkg::KW_INDEX_W-1:0]   keyword_index
);
    import lckm_pkg::*;

    localparam int LEN_W = $clog2(LINE_LIMIT);

    logic [KEYWORD_COUNT-1:0] cand_reg;
    logic [KEYWORD_COUNT-1:0] cand_next;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic                     valid_reg;
    logic [7:0]               echo_reg;
    match_result_t            result_reg;
    match_result_t            result_next;
    logic                     take;

    assign rx_ready = !valid_reg || res_ready;
    assign take     = rx_valid && rx_ready;

    lckm_match #(
        .KEYWORD_COUNT (KEYWORD_COUNT),
        .LINE_LIMIT    (LINE_LIMIT),
        .LEN_W         (LEN_W)
    ) u_match (
        .rx_byte          (rx_byte),
        .cand             (cand_reg),
        .line_length      (len_reg),
        .cand_next        (cand_next),
        .line_length_next (len_next),
        .result           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg  <= {KEYWORD_COUNT{1'b1}};
            len_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cand_reg <= cand_next;
                len_reg  <= len_next;
            end
            if (take)
                valid_reg <= 1'b1;
            else if (res_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            echo_reg   <= rx_byte;
            result_reg <= result_next;
        end
    end

    assign res_valid     = valid_reg;
    assign echo_byte     = echo_reg;
    assign line_done     = result_reg.line_done;
    assign keyword_found = result_reg.keyword_found;
    assign keyword_index = result_reg.keyword_index;

endmodule
